// ===== rtl/fnvp_pkg.sv =====
// package: shared types and codes for the fastcgi name-value parser
`timescale 1ns / 1ps
`default_nettype none
package fnvp_pkg;

    // parser phases
    localparam logic [1:0] PH_NAME_LEN  = 2'd0;
    localparam logic [1:0] PH_VALUE_LEN = 2'd1;
    localparam logic [1:0] PH_NAME      = 2'd2;
    localparam logic [1:0] PH_VALUE     = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    // long length marker in the first length byte
    localparam int LONG_FLAG_BIT = 7;

    localparam int LEN_W   = 31;
    localparam int COUNT_W = 33;

    typedef struct packed {
        logic [1:0]         phase;
        logic [1:0]         hdr_count;
        logic [LEN_W-1:0]   name_len;
        logic [LEN_W-1:0]   value_len;
        logic [LEN_W-1:0]   left;
        logic [COUNT_W-1:0] consumed;
    } state_t;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic [1:0]         kind;
        logic               field_last;
        logic               record_end;
        logic [COUNT_W-1:0] record_bytes;
        logic               truncated;
    } result_t;

endpackage
`default_nettype wire

// ===== rtl/fnvp_in_if.sv =====
// interface: input byte channel of the parser
`timescale 1ns / 1ps
`default_nettype none
interface fnvp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/fnvp_out_if.sv =====
// interface: result word channel of the parser
`timescale 1ns / 1ps
`default_nettype none
interface fnvp_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic [1:0]  kind;
    logic        field_last;
    logic        record_end;
    logic [32:0] record_bytes;
    logic        truncated;

    modport source (output valid, output out_byte, output kind, output field_last,
                    output record_end, output record_bytes, output truncated,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input field_last,
                    input record_end, input record_bytes, input truncated,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/fastcgi_name_value_parser.sv =====
// top level: fastcgi name-value record parser, one byte per cycle while not stalled
//
// byte_in carries one raw parameter byte per word, with buffer_end on the
// last byte of the available buffer. result_out gives at most one word per
// input byte: name and value bytes tagged by kind with field_last at field
// ends, record_end with record_bytes on the word that completes a record,
// and a header-only word (kind none) for an empty record or for a buffer that
// ends on a length byte. truncated marks a buffer end before the record is
// complete; the receiver drops the bytes of that record.
// throughput: one byte per cycle while byte_in.ready is high, set by the
// combinational parse step between the parser state register and the result register.
// each result word is registered when its byte is accepted. a two-entry
// output stage (result register plus skid register) keeps input flowing
// while the receiver stalls; byte_in.ready drops only when both are full.
// length bytes inside a record give no word.
// reset: rst_n clears the parser to expect a name length and empties the
// output stage.
`timescale 1ns / 1ps
`default_nettype none
module fastcgi_name_value_parser (
    input  wire       clk,
    input  wire       rst_n,
    fnvp_in_if.sink   byte_in,
    fnvp_out_if.source result_out
);
    import fnvp_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    logic    emit;
    result_t result;
    result_t out_data_reg;
    logic    out_valid_reg;
    result_t skid_data_reg;
    logic    skid_valid_reg;
    logic    in_take;
    logic    out_take;

    fnvp_step u_step (
        .state      (state_reg),
        .data_byte  (byte_in.data_byte),
        .buffer_end (byte_in.buffer_end),
        .state_next (state_next),
        .emit       (emit),
        .result     (result)
    );

    assign byte_in.ready = !skid_valid_reg;
    assign in_take       = byte_in.valid && !skid_valid_reg;
    assign out_take      = out_valid_reg && result_out.ready;

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (in_take)
            state_reg <= state_next;
    end

    // output stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_take)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                    out_valid_reg <= in_take && emit;
            end
            else if (!out_valid_reg)
                out_valid_reg <= in_take && emit;
            else if (in_take && emit)
                skid_valid_reg <= 1'b1;
        end
    end

    // output stage payload
    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else
                out_data_reg <= result;
        end
        else if (!out_valid_reg)
            out_data_reg <= result;
        else if (in_take && emit)
            skid_data_reg <= result;
    end

    assign result_out.valid        = out_valid_reg;
    assign result_out.out_byte     = out_data_reg.out_byte;
    assign result_out.kind         = out_data_reg.kind;
    assign result_out.field_last   = out_data_reg.field_last;
    assign result_out.record_end   = out_data_reg.record_end;
    assign result_out.record_bytes = out_data_reg.record_bytes;
    assign result_out.truncated    = out_data_reg.truncated;

endmodule
`default_nettype wire

// ===== rtl/fnvp_step.sv =====
// module: next-state and result logic for one parameter byte
`timescale 1ns / 1ps
`default_nettype none
module fnvp_step (
    input  fnvp_pkg::state_t  state,
    input  logic [7:0]        data_byte,
    input  logic              buffer_end,
    output fnvp_pkg::state_t  state_next,
    output logic              emit,
    output fnvp_pkg::result_t result
);
    import fnvp_pkg::*;

    logic [LEN_W-1:0]   len_in;
    logic [LEN_W-1:0]   len_new;
    logic [1:0]         hdr_new;
    logic               len_done;
    logic [COUNT_W-1:0] consumed_inc;
    logic               word_out;
    logic               done;
    logic               field_end;
    state_t             st;

    // length collector, one or four bytes
    always_comb
    begin
        len_in = (state.phase == PH_NAME_LEN) ? state.name_len : state.value_len;
        if (state.hdr_count == 2'd0)
        begin
            if (data_byte[LONG_FLAG_BIT])
            begin
                len_new  = {{(LEN_W-7){1'b0}}, data_byte[6:0]};
                hdr_new  = 2'd1;
                len_done = 1'b0;
            end
            else
            begin
                len_new  = {{(LEN_W-8){1'b0}}, data_byte};
                hdr_new  = 2'd0;
                len_done = 1'b1;
            end
        end
        else
        begin
            len_new  = {len_in[LEN_W-9:0], data_byte};
            hdr_new  = state.hdr_count + 2'd1;
            len_done = (hdr_new == 2'd0);
        end
    end

    assign consumed_inc = state.consumed + {{(COUNT_W-1){1'b0}}, 1'b1};
    assign field_end    = (state.left == {{(LEN_W-1){1'b0}}, 1'b1});

    // phase sequencing
    always_comb
    begin
        st            = state;
        st.consumed   = consumed_inc;
        word_out      = 1'b0;
        done          = 1'b0;
        result.out_byte   = 8'd0;
        result.kind       = KIND_NONE;
        result.field_last = 1'b0;
        case (state.phase)
            PH_NAME_LEN:
            begin
                st.name_len  = len_new;
                st.hdr_count = hdr_new;
                if (len_done)
                    st.phase = PH_VALUE_LEN;
            end
            PH_VALUE_LEN:
            begin
                st.value_len = len_new;
                st.hdr_count = hdr_new;
                if (len_done)
                begin
                    if (state.name_len != '0)
                    begin
                        st.phase = PH_NAME;
                        st.left  = state.name_len;
                    end
                    else if (len_new != '0)
                    begin
                        st.phase = PH_VALUE;
                        st.left  = len_new;
                    end
                    else
                    begin
                        word_out = 1'b1;
                        done     = 1'b1;
                    end
                end
            end
            PH_NAME:
            begin
                word_out          = 1'b1;
                result.out_byte   = data_byte;
                result.kind       = KIND_NAME;
                st.left           = state.left - {{(LEN_W-1){1'b0}}, 1'b1};
                if (field_end)
                begin
                    result.field_last = 1'b1;
                    if (state.value_len != '0)
                    begin
                        st.phase = PH_VALUE;
                        st.left  = state.value_len;
                    end
                    else
                        done = 1'b1;
                end
            end
            default:
            begin
                word_out          = 1'b1;
                result.out_byte   = data_byte;
                result.kind       = KIND_VALUE;
                st.left           = state.left - {{(LEN_W-1){1'b0}}, 1'b1};
                if (field_end)
                begin
                    result.field_last = 1'b1;
                    done              = 1'b1;
                end
            end
        endcase

        result.record_end   = done;
        result.record_bytes = done ? consumed_inc : '0;
        result.truncated    = buffer_end && !done;
        emit                = word_out || buffer_end;

        // record finished or buffer ended: back to the reset state
        if (done || buffer_end)
            state_next = '0;
        else
            state_next = st;
    end

endmodule
`default_nettype wire
